FILE: rtl/trbf_pkg.sv
// Shared types, codes and defaults for the two-reader broadcast FIFO.
package trbf_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 64;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Request codes carried on the input tuser.
    localparam req_t REQ_INSERT = 2'd0;
    localparam req_t REQ_READ_A = 2'd1;
    localparam req_t REQ_READ_B = 2'd2;

    // Status codes carried on the output tuser.
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming word
        logic exec;   // carry out the captured request
    } dp_cmd_t;

endpackage

FILE: rtl/two_reader_broadcast_fifo_top.sv
// Top level of the two-reader broadcast FIFO.
//
// A ring of DEPTH 64-bit records shared by two consumers, A and B. Every
// record must be read by both consumers before its slot is freed.
// Requests arrive on the s_ channel: tuser carries the request kind (insert,
// read by A, read by B) and tdata carries the record for an insert. Each
// request yields exactly one word on the m_ channel: tuser carries the
// status (success, nothing unread, full and dropped) and tdata carries the
// record read (zero unless a read succeeded) with the occupancy above it.
// An insert into a full ring is dropped and reported as full.
// A request accepted in the idle state is captured, carried out in the
// execute state and presented in the output state, where m_tvalid stays
// high until the receiver takes it. One request is in flight at a time:
// s_tready stays low from the accept until the result is taken, so the
// block takes a new request only after the last one has left.
// The execute state does the pointer update and at most one ring access.
// When the receiver stalls, the result word holds and s_tready stays low.
// Reset empties the ring: all pointers and the occupancy return to zero and
// the block is ready for a request at once; record contents are not cleared.
module two_reader_broadcast_fifo_top #(
    parameter int DEPTH = trbf_pkg::DEPTH_DEF,
    localparam int OCC_W = $clog2(DEPTH + 1),
    localparam int OUT_W = ((trbf_pkg::DATA_W + OCC_W + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [trbf_pkg::DATA_W-1:0] s_tdata,  // [63:0] write_data
    input  trbf_pkg::req_t              s_tuser,  // [1:0] req_type
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_W-1:0]            m_tdata,  // read_data, occupancy, zero fill
    output trbf_pkg::status_t           m_tuser   // [1:0] status
);
    import trbf_pkg::*;

    dp_cmd_t           cmd;
    logic [DATA_W-1:0] read_data;
    logic [OCC_W-1:0]  occupancy;

    // The controller only sequences the handshakes; the ring, pointers and results live in the datapath.
    trbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    trbf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_req    (s_tuser),
        .in_data   (s_tdata),
        .status    (m_tuser),
        .read_data (read_data),
        .occupancy (occupancy)
    );

    // The record sits in the low 64 bits with the occupancy just above it.
    assign m_tdata = OUT_W'({occupancy, read_data});

endmodule

FILE: rtl/trbf_datapath.sv
// Datapath of the two-reader broadcast FIFO: record ring, pointers and result registers.
module trbf_datapath #(
    parameter int DEPTH = trbf_pkg::DEPTH_DEF,
    localparam int OCC_W = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  trbf_pkg::dp_cmd_t             cmd,
    input  trbf_pkg::req_t                in_req,
    input  logic [trbf_pkg::DATA_W-1:0]   in_data,
    output trbf_pkg::status_t             status,
    output logic [trbf_pkg::DATA_W-1:0]   read_data,
    output logic [OCC_W-1:0]              occupancy
);
    import trbf_pkg::*;

    localparam int PTR_W  = $clog2(2 * DEPTH);
    localparam int PTR_XW = PTR_W + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(2 * DEPTH - 1);
    localparam logic [PTR_W-1:0]  PTR_DEPTH = PTR_W'(DEPTH);
    localparam logic [PTR_XW-1:0] PTR_MOD   = PTR_XW'(2 * DEPTH);
    localparam logic [OCC_W-1:0]  OCC_FULL  = OCC_W'(DEPTH);

    // Pointers run modulo twice the depth so that full and empty differ.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
        return (p >= PTR_DEPTH) ? ADDR_W'(p - PTR_DEPTH) : ADDR_W'(p);
    endfunction

    function automatic logic [OCC_W-1:0] unread(input logic [PTR_W-1:0] tail,
                                                input logic [PTR_W-1:0] rd);
        logic [PTR_XW-1:0] d;
        d = {1'b0, tail} - {1'b0, rd};
        if (d[PTR_W])
        begin
            d = d + PTR_MOD;
        end
        return OCC_W'(d);
    endfunction

    logic [DATA_W-1:0] mem [DEPTH];

    req_t              req_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic [DATA_W-1:0] rd_reg;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [PTR_W-1:0]  ra_reg, ra_next;
    logic [PTR_W-1:0]  rb_reg, rb_next;
    logic [OCC_W-1:0]  fill_reg, fill_next;
    status_t           status_reg, status_next;
    logic              sel_reg, sel_next;

    logic              wr_en;
    logic [ADDR_W-1:0] rd_slot;
    logic [OCC_W-1:0]  unread_a, unread_b, new_a, new_b;

    assign unread_a = unread(tail_reg, ra_reg);
    assign unread_b = unread(tail_reg, rb_reg);

    always_comb
    begin
        tail_next   = tail_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        status_next = ST_EMPTY;
        sel_next    = 1'b0;
        wr_en       = 1'b0;
        rd_slot     = ptr_slot(ra_reg);
        case (req_reg)
            REQ_INSERT:
            begin
                if (fill_reg >= OCC_FULL)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en       = 1'b1;
                    tail_next   = ptr_inc(tail_reg);
                    status_next = ST_OK;
                end
            end
            REQ_READ_A:
            begin
                if (unread_a != '0)
                begin
                    ra_next     = ptr_inc(ra_reg);
                    status_next = ST_OK;
                    sel_next    = 1'b1;
                end
            end
            REQ_READ_B:
            begin
                rd_slot = ptr_slot(rb_reg);
                if (unread_b != '0)
                begin
                    rb_next     = ptr_inc(rb_reg);
                    status_next = ST_OK;
                    sel_next    = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_EMPTY;
            end
        endcase
        new_a     = unread(tail_next, ra_next);
        new_b     = unread(tail_next, rb_next);
        fill_next = (new_a > new_b) ? new_a : new_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg   <= '0;
            ra_reg     <= '0;
            rb_reg     <= '0;
            fill_reg   <= '0;
            status_reg <= ST_EMPTY;
            sel_reg    <= 1'b0;
        end
        else if (cmd.exec)
        begin
            tail_reg   <= tail_next;
            ra_reg     <= ra_next;
            rb_reg     <= rb_next;
            fill_reg   <= fill_next;
            status_reg <= status_next;
            sel_reg    <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= in_req;
            wdata_reg <= in_data;
        end
    end

    // Record ring: at most one write or one registered read per request.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[ptr_slot(tail_reg)] <= wdata_reg;
        end
        if (cmd.exec && sel_next)
        begin
            rd_reg <= mem[rd_slot];
        end
    end

    assign status    = status_reg;
    assign read_data = sel_reg ? rd_reg : '0;
    assign occupancy = fill_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= OCC_FULL)
        else $error("fill count above depth");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && req_reg == REQ_INSERT && fill_reg != OCC_FULL) |=>
            (tail_reg != $past(tail_reg) && status_reg == ST_OK))
        else $error("insert into a ring with room did not advance the tail");

    a_read_moves_one: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && req_reg == REQ_READ_A && unread_a != '0) |=>
            (ra_reg != $past(ra_reg) && rb_reg == $past(rb_reg) && sel_reg))
        else $error("read by consumer A moved the wrong pointer");

endmodule

FILE: rtl/trbf_ctrl.sv
// Controller of the two-reader broadcast FIFO: handshake sequencing state machine.
module trbf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output trbf_pkg::dp_cmd_t cmd
);
    import trbf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg    <= S_EXEC;
                        s_tready_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    state_reg    <= S_OUT;
                    m_tvalid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg    <= S_IDLE;
                        m_tvalid_reg <= 1'b0;
                        s_tready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    s_tready_reg <= 1'b1;
                    m_tvalid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;
    assign cmd.load = s_tvalid && s_tready_reg;
    assign cmd.exec = (state_reg == S_EXEC);

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output open at the same time");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> ##1 m_tvalid)
        else $error("result not presented two cycles after accept");

    a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> (!cmd.exec && m_tvalid))
        else $error("request executed twice or result missing");

endmodule
